FILE: hdl/mavg_pkg.sv
`default_nettype none

package mavg_pkg;

  // Sizes of the sample path and the window.
  localparam int SAMPLE_BITS  = 16;
  localparam int CFG_BITS     = 8;
  localparam int MAX_WINDOW   = 128;
  localparam int WIN_BITS     = $clog2(MAX_WINDOW + 1);
  localparam int TOTAL_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CNT_BITS     = $clog2(SAMPLE_BITS);
  localparam int WINDOW_RESET = 4;

  // Divider sequencer states.
  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_e;

  // Requests from the filter to the divider.
  typedef struct packed {
    logic start;
    logic take;
  } div_ctrl_t;

  // Divider status seen by the filter.
  typedef struct packed {
    logic idle;
    logic done;
  } div_stat_t;

  // A window of zero acts as one, and anything above the cell count is capped.
  function automatic logic [WIN_BITS-1:0] clamp_window(input logic [CFG_BITS-1:0] raw);
    logic [31:0] w;
    begin
      w = 32'(raw);
      if (w == 32'd0) begin
        w = 32'd1;
      end
      if (w > 32'(MAX_WINDOW)) begin
        w = 32'(MAX_WINDOW);
      end
      return WIN_BITS'(w);
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mavg_if.sv
`default_nettype none

// Input sample channel.
interface mavg_sample_if;
  logic                             valid;
  logic                             ready;
  logic [mavg_pkg::SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

// Result channel.
interface mavg_average_if;
  logic                             valid;
  logic                             ready;
  logic [mavg_pkg::SAMPLE_BITS-1:0] average_value;

  modport source (output valid, output average_value, input ready);
  modport sink (input valid, input average_value, output ready);
endinterface

// Window length write channel.
interface mavg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mavg_pkg::CFG_BITS-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

`default_nettype wire

FILE: hdl/mavg_cell.sv
`default_nettype none

module mavg_cell (
  input  wire logic                             clk_i,
  input  wire logic                             shift_i,
  input  wire logic                             tail_i,
  input  wire logic [mavg_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire logic [mavg_pkg::SAMPLE_BITS-1:0] next_i,
  output      logic [mavg_pkg::SAMPLE_BITS-1:0] data_o
);

  logic [mavg_pkg::SAMPLE_BITS-1:0] data_d;
  logic [mavg_pkg::SAMPLE_BITS-1:0] data_q;

  // The tail cell of the active window takes the new sample; the others take
  // their upstream neighbor, so once the window is full the oldest sample sits in cell zero.
  assign data_d = tail_i ? sample_i : next_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: hdl/mavg_div.sv
`default_nettype none

module mavg_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mavg_pkg::div_ctrl_t              ctrl_i,
  input  wire logic [mavg_pkg::TOTAL_BITS-1:0]  dividend_i,
  input  wire logic [mavg_pkg::WIN_BITS-1:0]    divisor_i,
  output      mavg_pkg::div_stat_t              stat_o,
  output      logic [mavg_pkg::SAMPLE_BITS-1:0] quotient_o
);

  mavg_pkg::div_state_e state_d, state_q;
  logic [mavg_pkg::CNT_BITS-1:0]    cnt_d, cnt_q;
  logic [mavg_pkg::WIN_BITS-1:0]    rem_d, rem_q;
  logic [mavg_pkg::SAMPLE_BITS-1:0] quo_d, quo_q;
  logic [mavg_pkg::WIN_BITS-1:0]    dvs_q;
  logic [mavg_pkg::WIN_BITS:0]      shifted;
  logic [mavg_pkg::WIN_BITS:0]      diff;
  logic                             ge;

  // One restoring step: bring down the next dividend bit and try the divisor.
  // The sum is below divisor times 2^SAMPLE_BITS, so its upper bits start as a
  // valid partial remainder and only the low bits need steps.
  always_comb begin
    shifted = {rem_q, quo_q[mavg_pkg::SAMPLE_BITS-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_d   = ge ? diff[mavg_pkg::WIN_BITS-1:0] : shifted[mavg_pkg::WIN_BITS-1:0];
    quo_d   = {quo_q[mavg_pkg::SAMPLE_BITS-2:0], ge};
  end

  // Sequencer: load, step once per bit, then hold until the result is taken.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      mavg_pkg::DIV_IDLE: begin
        if (ctrl_i.start) begin
          state_d = mavg_pkg::DIV_RUN;
          cnt_d   = '0;
        end
      end
      mavg_pkg::DIV_RUN: begin
        cnt_d = cnt_q + mavg_pkg::CNT_BITS'(1);
        if (cnt_q == mavg_pkg::CNT_BITS'(mavg_pkg::SAMPLE_BITS - 1)) begin
          state_d = mavg_pkg::DIV_DONE;
        end
      end
      mavg_pkg::DIV_DONE: begin
        if (ctrl_i.take) begin
          state_d = mavg_pkg::DIV_IDLE;
        end
      end
      default: begin
        state_d = mavg_pkg::DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mavg_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == mavg_pkg::DIV_IDLE && ctrl_i.start) begin
      rem_q <= mavg_pkg::WIN_BITS'(dividend_i[mavg_pkg::TOTAL_BITS-1:mavg_pkg::SAMPLE_BITS]);
      quo_q <= dividend_i[mavg_pkg::SAMPLE_BITS-1:0];
      dvs_q <= divisor_i;
    end else if (state_q == mavg_pkg::DIV_RUN) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.idle = (state_q == mavg_pkg::DIV_IDLE);
  assign stat_o.done = (state_q == mavg_pkg::DIV_DONE);
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire

FILE: hdl/moving_average_filter.sv
// Moving average filter built as a row of sample cells and a bit-serial divider.
// A sample that completes a window starts a divide; the next sample is taken once
// its result is in the output register. Samples that only fill the window are
// taken one per cycle while the divider is idle and no window write is offered;
// in steady state a sample waits for the one-bit-per-cycle divide by the window.
// Reset sets the window to 4 with an empty history; no clearing pass is needed.
`default_nettype none

module moving_average_filter (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  mavg_sample_if.sink    sample_i,
  mavg_cfg_if.sink       cfg_i,
  mavg_average_if.source average_o
);

  logic [mavg_pkg::WIN_BITS-1:0]    win_d, win_q;
  logic [mavg_pkg::WIN_BITS-1:0]    fill_d, fill_q;
  logic [mavg_pkg::WIN_BITS-1:0]    fill_next;
  logic [mavg_pkg::TOTAL_BITS-1:0]  total_d, total_q;
  logic [mavg_pkg::TOTAL_BITS-1:0]  leaving;
  logic                             out_valid_d, out_valid_q;
  logic [mavg_pkg::SAMPLE_BITS-1:0] out_data_q;
  logic                             in_acc;
  logic                             cfg_acc;
  logic                             full;
  logic                             produce;
  logic [mavg_pkg::MAX_WINDOW-1:0]  tail;
  logic [mavg_pkg::SAMPLE_BITS-1:0] cell_data [mavg_pkg::MAX_WINDOW];
  logic [mavg_pkg::SAMPLE_BITS-1:0] quotient;
  mavg_pkg::div_ctrl_t              div_ctrl;
  mavg_pkg::div_stat_t              div_stat;

  // Handshakes: a sample request is taken whenever the divider is free and no
  // window write is offered in the same cycle.
  assign sample_i.ready = div_stat.idle & ~cfg_i.valid;
  assign cfg_i.ready    = 1'b1;
  assign in_acc         = sample_i.valid & sample_i.ready;
  assign cfg_acc        = cfg_i.valid & cfg_i.ready;

  // Row of cells; the cell at window minus one is the entry point.
  for (genvar i = 0; i < mavg_pkg::MAX_WINDOW; i++) begin : g_cell
    logic [mavg_pkg::SAMPLE_BITS-1:0] next_data;

    assign tail[i] = (win_q == mavg_pkg::WIN_BITS'(i + 1));

    if (i == mavg_pkg::MAX_WINDOW - 1) begin : g_last
      assign next_data = sample_i.sample_value;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    mavg_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (in_acc),
      .tail_i   (tail[i]),
      .sample_i (sample_i.sample_value),
      .next_i   (next_data),
      .data_o   (cell_data[i])
    );
  end

  // Running sum and fill count. Once full, the oldest sample in cell zero leaves.
  always_comb begin
    full      = (fill_q == win_q);
    leaving   = full ? mavg_pkg::TOTAL_BITS'(cell_data[0]) : '0;
    fill_next = full ? fill_q : fill_q + mavg_pkg::WIN_BITS'(1);
    produce   = (fill_next == win_q);
    win_d     = win_q;
    fill_d    = fill_q;
    total_d   = total_q;
    if (cfg_acc) begin
      win_d   = mavg_pkg::clamp_window(cfg_i.window_length);
      fill_d  = '0;
      total_d = '0;
    end else if (in_acc) begin
      fill_d  = fill_next;
      total_d = total_q + mavg_pkg::TOTAL_BITS'(sample_i.sample_value) - leaving;
    end
  end

  // Divider requests.
  assign div_ctrl.start = in_acc & ~cfg_acc & produce;
  assign div_ctrl.take  = div_stat.done & (~out_valid_q | average_o.ready);

  mavg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (total_d),
    .divisor_i  (win_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (div_ctrl.take) begin
      out_valid_d = 1'b1;
    end else if (average_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= mavg_pkg::clamp_window(mavg_pkg::CFG_BITS'(mavg_pkg::WINDOW_RESET));
      fill_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ctrl.take) begin
      out_data_q <= quotient;
    end
  end

  assign average_o.valid         = out_valid_q;
  assign average_o.average_value = out_data_q;

`ifndef NO_ASSERTIONS
  // The fill count never passes the window.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win_q)
    else $error("fill count above window");

  // An empty history has a zero sum.
  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (total_q == '0))
    else $error("nonzero sum with empty history");

  // A started divide leaves the idle state.
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |=> !div_stat.idle)
    else $error("divider did not start");

  // A result only appears after a finished divide.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(div_stat.done))
    else $error("result without divide");
`endif

endmodule

`default_nettype wire
